// File: design/vlts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlts_pkg
// Shared types and constants of the video line type sequencer.
// ----------------------------------------------------------------------------
package vlts_pkg;

    localparam int CODE_W  = 6;
    localparam int COUNT_W = 16;
    localparam int WORD_W  = 16;
    localparam int PTR_W   = 8;

    localparam logic [CODE_W-1:0] CODE_MASK = 6'h3F;
    localparam logic [CODE_W-1:0] BANK_BITS = 6'h3C;
    localparam logic [CODE_W-1:0] TYPE_BITS = 6'h03;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_WRITE  = 2'd1,
        MODE_SWITCH = 2'd2
    } mode_t;

endpackage

// File: design/vlts_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlts channels
// Valid/ready channel interfaces for the item input and the result output.
// ----------------------------------------------------------------------------
interface vlts_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  table_address;
    logic [15:0] table_word;
    logic [7:0]  next_table_start;

    modport source (output valid, output mode, output table_address,
                    output table_word, output next_table_start, input ready);
    modport sink   (input valid, input mode, input table_address,
                    input table_word, input next_table_start, output ready);
endinterface

interface vlts_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] line_code;
    logic       code_updated;

    modport source (output valid, output line_code, output code_updated, input ready);
    modport sink   (input valid, input line_code, input code_updated, output ready);
endinterface

// File: design/vlts_table_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlts_table_ram
// Single write port, single read port table memory with registered read data.
// ----------------------------------------------------------------------------
module vlts_table_ram
    import vlts_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/video_line_type_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_line_type_sequencer
// Walks a run-length table of line codes, one step per video line tick.
// ----------------------------------------------------------------------------
// usage
//   item: valid/ready input; mode 0 is a line tick, 1 writes a table word at
//   table_address, 2 requests a switch to the table at next_table_start.
//   result: valid/ready output, one beat per item: line_code and code_updated.
// throughput and order
//   writes, switch requests, unused modes and ticks that do not exhaust the
//   line count: result registered the cycle after acceptance, one item per
//   cycle while results are taken. a tick that exhausts the count reads the
//   next table word from the synchronous table memory (ST_FETCH); a terminator
//   adds a read at the table start (ST_RESTART); the input is held off meanwhile.
// reset
//   control state returns to table start 0, line count 1, blanking on, code 0;
//   the table memory is not cleared and must be written before it is walked.
// stall
//   the result register frees itself when taken, so a new item is accepted in
//   the same cycle the receiver takes the pending result; a stalled receiver
//   holds off the input.
// TABLE_DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module video_line_type_sequencer
    import vlts_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    vlts_in_if.sink     item,
    vlts_out_if.source  result
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = (AW > PTR_W + 1) ? AW : PTR_W + 1;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FETCH,
        ST_RESTART
    } state_t;

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   active_start_reg, active_start_next;
    logic [PTR_W-1:0]   entry_index_reg, entry_index_next;
    logic [COUNT_W-1:0] lines_left_reg, lines_left_next;
    logic [PTR_W-1:0]   pending_start_reg, pending_start_next;
    logic               switch_pending_reg, switch_pending_next;
    logic               blank_active_reg, blank_active_next;
    logic [CODE_W-1:0]  status_code_reg, status_code_next;
    logic               out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]  out_code_reg, out_code_next;
    logic               out_updated_reg, out_updated_next;

    logic               accept;
    logic [COUNT_W-1:0] lines_dec;
    logic [PTR_W-1:0]   rd_base;
    logic [PTR_W-1:0]   rd_offset;
    logic [SW-1:0]      rd_sum;
    logic [SW-1:0]      wr_ext;
    logic               rd_en;
    logic               wr_en;
    logic [WORD_W-1:0]  rd_data;
    logic [CODE_W-1:0]  fetched_code;

    assign item.ready      = (state_reg == ST_RUN) && (!out_valid_reg || result.ready);
    assign accept          = item.valid && item.ready;
    assign result.valid    = out_valid_reg;
    assign result.line_code    = out_code_reg;
    assign result.code_updated = out_updated_reg;

    assign lines_dec = lines_left_reg - COUNT_W'(1);
    assign rd_sum    = SW'(rd_base) + SW'(rd_offset);
    assign wr_ext    = SW'(item.table_address);
    assign wr_en     = accept && (item.mode == MODE_WRITE);

    // blanking as it stands after any swap done in this cycle
    assign fetched_code = rd_data[CODE_W-1:0] & CODE_MASK & (BANK_BITS | TYPE_BITS)
                          & (blank_active_next ? ~BANK_BITS : CODE_MASK);

    vlts_table_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_ext[AW-1:0]),
        .wr_data (item.table_word),
        .rd_en   (rd_en),
        .rd_addr (rd_sum[AW-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next          = state_reg;
        active_start_next   = active_start_reg;
        entry_index_next    = entry_index_reg;
        lines_left_next     = lines_left_reg;
        pending_start_next  = pending_start_reg;
        switch_pending_next = switch_pending_reg;
        blank_active_next   = blank_active_reg;
        status_code_next    = status_code_reg;
        out_valid_next      = out_valid_reg && !result.ready;
        out_code_next       = out_code_reg;
        out_updated_next    = out_updated_reg;
        rd_en               = 1'b0;
        rd_base             = active_start_reg;
        rd_offset           = entry_index_reg + PTR_W'(1);

        case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    out_valid_next   = 1'b1;
                    out_code_next    = status_code_reg;
                    out_updated_next = 1'b0;
                    case (mode_t'(item.mode))
                        MODE_TICK:
                        begin
                            lines_left_next = lines_dec;
                            if (lines_dec == '0)
                            begin
                                // count exhausted: fetch the next word
                                out_valid_next   = 1'b0;
                                entry_index_next = entry_index_reg + PTR_W'(1);
                                rd_en            = 1'b1;
                                state_next       = ST_FETCH;
                            end
                        end
                        MODE_WRITE:
                        begin
                        end
                        MODE_SWITCH:
                        begin
                            blank_active_next   = 1'b1;
                            status_code_next    = status_code_reg & ~BANK_BITS;
                            pending_start_next  = item.next_table_start;
                            switch_pending_next = 1'b1;
                            out_code_next       = status_code_reg & ~BANK_BITS;
                            out_updated_next    = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                if (rd_data == '0)
                begin
                    // terminator: swap in a pending table if any, restart at the table head
                    if (switch_pending_reg)
                    begin
                        switch_pending_next = 1'b0;
                        blank_active_next   = 1'b0;
                        active_start_next   = pending_start_reg;
                        rd_base             = pending_start_reg;
                    end
                    entry_index_next = '0;
                    rd_offset        = '0;
                    rd_en            = 1'b1;
                    state_next       = ST_RESTART;
                end
                else
                begin
                    lines_left_next  = COUNT_W'(rd_data[WORD_W-1:PTR_W]);
                    status_code_next = fetched_code;
                    out_valid_next   = 1'b1;
                    out_code_next    = fetched_code;
                    out_updated_next = 1'b1;
                    state_next       = ST_RUN;
                end
            end
            ST_RESTART:
            begin
                lines_left_next  = COUNT_W'(rd_data[WORD_W-1:PTR_W]);
                status_code_next = fetched_code;
                out_valid_next   = 1'b1;
                out_code_next    = fetched_code;
                out_updated_next = 1'b1;
                state_next       = ST_RUN;
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_RUN;
            active_start_reg   <= '0;
            entry_index_reg    <= '0;
            lines_left_reg     <= COUNT_W'(1);
            pending_start_reg  <= '0;
            switch_pending_reg <= 1'b0;
            blank_active_reg   <= 1'b1;
            status_code_reg    <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            active_start_reg   <= active_start_next;
            entry_index_reg    <= entry_index_next;
            lines_left_reg     <= lines_left_next;
            pending_start_reg  <= pending_start_next;
            switch_pending_reg <= switch_pending_next;
            blank_active_reg   <= blank_active_next;
            status_code_reg    <= status_code_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_code_reg    <= out_code_next;
        out_updated_reg <= out_updated_next;
    end

    // the result register is always free while a table read is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_RUN) |-> !out_valid_reg)
        else $error("result pending during table fetch");

    // blanking keeps the bank bits clear
    assert property (@(posedge clk) disable iff (!rst_n)
        blank_active_reg |-> (status_code_reg[5:2] == 4'd0))
        else $error("bank bits set while blanking");

    // a restart read is always at the head of the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESTART) |-> (entry_index_reg == '0))
        else $error("restart away from table head");

    // an exhausting tick always starts a fetch
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.mode == MODE_TICK) && (lines_left_reg == COUNT_W'(1)))
        |=> (state_reg == ST_FETCH))
        else $error("exhausted count without fetch");

endmodule

// File: tb/video_line_type_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_line_type_sequencer_tb
// Self-checking bench for the video line type sequencer. Beats are driven on
// the item channel with random gaps, and each result beat is checked against
// a line code predictor that walks its own copy of the run-length table.
// Ticks are only sent once every table word they would read has been written.
// Covers table writes, switch requests, the unused mode, terminator swaps,
// table address wrap, a zero first word and a count of zero wrapping to 65535.
// ----------------------------------------------------------------------------
module video_line_type_sequencer_tb;
    import vlts_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int STALL_CYCLES = 300;

    typedef struct packed {
        logic [CODE_W-1:0] line_code;
        logic              code_updated;
    } line_result_t;

    class line_code_scoreboard;
        logic [WORD_W-1:0]  table_mem [256];
        bit                 written [256];
        bit [PTR_W-1:0]     active_start;
        bit [PTR_W-1:0]     entry_index;
        bit [PTR_W-1:0]     pending_start;
        bit [COUNT_W-1:0]   lines_left;
        bit                 switch_pending;
        bit                 blank_active;
        bit [CODE_W-1:0]    status_code;
        line_result_t       expected_q[$];
        int                 errors;
        int                 checked;
        int                 beats_in;
        int                 fetches;
        int                 swaps;

        function new();
            active_start   = '0;
            entry_index    = '0;
            pending_start  = '0;
            lines_left     = 16'd1;
            switch_pending = 1'b0;
            blank_active   = 1'b1;
            status_code    = '0;
            foreach (written[i])
                written[i] = 1'b0;
        endfunction

        // address of a table word the next tick would read before it was written
        function bit next_unwritten(output bit [PTR_W-1:0] addr, output bit at_start);
            bit [PTR_W-1:0] a;
            addr     = '0;
            at_start = 1'b0;
            if (lines_left != 16'd1)
                return 1'b0;
            a = active_start + entry_index + 8'd1;
            if (!written[a])
            begin
                addr = a;
                return 1'b1;
            end
            if (table_mem[a] == '0)
            begin
                a = switch_pending ? pending_start : active_start;
                if (!written[a])
                begin
                    addr     = a;
                    at_start = 1'b1;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_input(logic [1:0] mode, logic [PTR_W-1:0] addr,
                                 logic [WORD_W-1:0] word, logic [PTR_W-1:0] start);
            line_result_t   r;
            logic [WORD_W-1:0] w;
            bit [PTR_W-1:0] a;
            r.code_updated = 1'b0;
            beats_in++;
            case (mode)
                MODE_TICK:
                begin
                    lines_left = lines_left - 16'd1;
                    if (lines_left == '0)
                    begin
                        entry_index = entry_index + 8'd1;
                        a = active_start + entry_index;
                        w = table_mem[a];
                        if (w == '0)
                        begin
                            // terminator: swap in the requested table, back to its start
                            if (switch_pending)
                            begin
                                switch_pending = 1'b0;
                                blank_active   = 1'b0;
                                active_start   = pending_start;
                                swaps++;
                            end
                            entry_index = '0;
                            w = table_mem[active_start];
                        end
                        lines_left  = {8'd0, w[15:8]};
                        status_code = w[CODE_W-1:0];
                        if (blank_active)
                            status_code = status_code & ~BANK_BITS;
                        r.code_updated = 1'b1;
                        fetches++;
                    end
                end
                MODE_WRITE:
                begin
                    table_mem[addr] = word;
                    written[addr]   = 1'b1;
                end
                MODE_SWITCH:
                begin
                    blank_active   = 1'b1;
                    status_code    = status_code & ~BANK_BITS;
                    pending_start  = start;
                    switch_pending = 1'b1;
                    r.code_updated = 1'b1;
                end
                default: ;
            endcase
            r.line_code = status_code;
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100)
                $display("[%0t] MISMATCH %s", $time, msg);
        endtask

        task check_result(logic [CODE_W-1:0] code, logic updated);
            line_result_t e;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result beat: line_code %02h code_updated %b",
                                 code, updated));
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (code !== e.line_code)
                report($sformatf("beat %0d line_code: expected %02h, got %02h",
                                 checked, e.line_code, code));
            if (updated !== e.code_updated)
                report($sformatf("beat %0d code_updated: expected %b, got %b",
                                 checked, e.code_updated, updated));
        endtask

        task flush_check();
            if (expected_q.size() != 0)
                report($sformatf("%0d expected results never arrived", expected_q.size()));
        endtask
    endclass

    logic clk;
    logic rst_n;

    vlts_in_if  item_ch ();
    vlts_out_if result_ch ();

    video_line_type_sequencer DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    line_code_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int cycles;
    bit pressure_go;
    bit stall_hold;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // long receiver hold-off so the result register fills and the input stalls
    initial
    begin
        stall_hold = 1'b0;
        wait (pressure_go);
        stall_hold <= 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_hold <= 1'b0;
    end

    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.line_code, result_ch.code_updated);
            result_ch.ready <= !stall_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [7:0] rand8();
        return 8'($urandom);
    endfunction

    function automatic logic [15:0] rand16();
        return 16'($urandom);
    endfunction

    task automatic send_item(logic [1:0] mode, logic [PTR_W-1:0] addr,
                             logic [WORD_W-1:0] word, logic [PTR_W-1:0] start);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid            <= 1'b1;
        item_ch.mode             <= mode;
        item_ch.table_address    <= addr;
        item_ch.table_word       <= word;
        item_ch.next_table_start <= start;
        do
            @(posedge clk);
        while (!item_ch.ready);
        sb.note_input(mode, addr, word, start);
        if (mode != MODE_UNUSED)
            items_sent++;
    endtask

    function automatic logic [WORD_W-1:0] walk_word();
        logic [WORD_W-1:0] w;
        w = rand16();
        w[15:8] = ($urandom_range(9) == 0) ? 8'($urandom_range(4, 12))
                                           : 8'($urandom_range(1, 3));
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] fill_word();
        if ($urandom_range(4) == 0)
            return '0;
        return walk_word();
    endfunction

    function automatic logic [WORD_W-1:0] noise_word();
        logic [WORD_W-1:0] w;
        w = rand16();
        if ($urandom_range(1) == 0)
            w[15:8] = 8'($urandom_range(1, 4));
        if (w[15:8] == 8'd0)
            w[15:8] = 8'd1;
        return w;
    endfunction

    // fill any table word the tick would read first; a table head never gets zero
    task automatic send_tick();
        bit [PTR_W-1:0] a;
        bit             at_start;
        while (sb.next_unwritten(a, at_start))
            send_item(MODE_WRITE, a, at_start ? walk_word() : fill_word(), rand8());
        send_item(MODE_TICK, rand8(), rand16(), rand8());
    endtask

    task automatic directed_items();
        send_item(MODE_UNUSED, 8'hFF, 16'hFFFF, 8'hFF);
        send_item(MODE_WRITE, 8'h01, 16'h01FF, 8'h00);
        send_item(MODE_WRITE, 8'h02, 16'h0000, 8'hFF);
        send_item(MODE_WRITE, 8'h00, 16'h0236, 8'h00);
        send_item(MODE_WRITE, 8'hFF, 16'hFFFF, 8'h00);
        send_tick();
        send_tick();
        // second request replaces the first before the swap
        send_item(MODE_SWITCH, 8'h00, 16'h0000, 8'hFA);
        send_item(MODE_SWITCH, 8'hFF, 16'hFFFF, 8'hFC);
        // table that runs past the top of the memory and wraps to address 0
        send_item(MODE_WRITE, 8'hFC, 16'h012D, 8'h00);
        send_item(MODE_WRITE, 8'hFD, 16'h0119, 8'h00);
        send_item(MODE_WRITE, 8'hFE, 16'h0107, 8'h00);
        send_item(MODE_WRITE, 8'hFF, 16'h0130, 8'h00);
        repeat (10) send_tick();
        send_item(MODE_SWITCH, 8'h00, 16'h0000, 8'h00);
        repeat (2) send_tick();
    endtask

    task automatic build_table_run();
        bit [PTR_W-1:0] s;
        int len;
        int n;
        s   = rand8();
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++)
            send_item(MODE_WRITE, s + 8'(i), walk_word(), rand8());
        send_item(MODE_WRITE, s + 8'(len), 16'h0000, rand8());
        if ($urandom_range(3) == 0)
            send_item(MODE_SWITCH, rand8(), rand16(), rand8());
        send_item(MODE_SWITCH, rand8(), rand16(), s);
        n = $urandom_range(6, 24);
        repeat (n)
        begin
            if ($urandom_range(9) == 0)
                send_item(MODE_UNUSED, rand8(), rand16(), rand8());
            send_tick();
        end
    endtask

    task automatic noise_item();
        case ($urandom_range(3))
            0: send_tick();
            1: send_item(MODE_WRITE, rand8(), noise_word(), rand8());
            2: send_item(MODE_SWITCH, rand8(), rand16(), rand8());
            default: send_item(MODE_UNUSED, rand8(), rand16(), rand8());
        endcase
    endtask

    task automatic run_random(int target);
        while (items_sent < target)
        begin
            if ($urandom_range(99) < 70)
                build_table_run();
            else
                noise_item();
        end
    endtask

    // table whose first word is zero and which holds a count-zero word
    task automatic zero_count_run();
        bit [PTR_W-1:0] next_rd;
        bit [PTR_W-1:0] s;
        int n;
        next_rd = sb.active_start + sb.entry_index + 8'd1;
        s       = next_rd + 8'd16;
        send_item(MODE_WRITE, s, 16'h0000, rand8());
        send_item(MODE_WRITE, s + 8'd1, {8'd1, rand8()}, rand8());
        send_item(MODE_WRITE, s + 8'd2, {8'd0, 8'($urandom_range(1, 255))}, rand8());
        send_item(MODE_WRITE, s + 8'd3, {8'd2, rand8()}, rand8());
        send_item(MODE_WRITE, s + 8'd4, 16'h0000, rand8());
        send_item(MODE_SWITCH, rand8(), rand16(), s);
        send_item(MODE_WRITE, next_rd, 16'h0000, rand8());
        n = 0;
        while (sb.switch_pending && (n < 300))
        begin
            send_tick();
            n++;
        end
        // the zero count wraps to 65535, so these ticks fetch nothing
        repeat (6) send_tick();
    endtask

    initial
    begin
        sb = new();
        rst_n                    = 1'b0;
        item_ch.valid            = 1'b0;
        item_ch.mode             = MODE_TICK;
        item_ch.table_address    = '0;
        item_ch.table_word       = '0;
        item_ch.next_table_start = '0;
        send_idle_pct = 35;
        recv_idle_pct = 74;
        items_sent    = 0;
        pressure_go   = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();
        pressure_go = 1'b1;
        run_random(140);

        send_idle_pct = 74;
        recv_idle_pct = 35;
        run_random(270);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(370);
        zero_count_run();
        item_ch.valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        sb.flush_check();

        $display("summary: %0d beats in, %0d results checked, %0d table fetches, %0d swaps",
                 sb.beats_in, sb.checked, sb.fetches, sb.swaps);
        $display("summary: three idle mixes, long output stall, address wrap, zero-count wrap");
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
